@@ rtl/mroe_pkg.sv @@
// Shared types and constants for the matrix row operation engine.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package mroe_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam int FUNC_W     = 3;
  localparam int IDX_W      = 4;
  localparam int SCALAR_W   = 16;
  localparam int DATA_W     = 32;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CNT_W      = 9;
  localparam int CALC_W     = 17;
  localparam int PROD_W     = 48;
  localparam int SUM_W      = 49;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SWAP  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCALE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SWAP,
    OP_SCALE,
    OP_ADD
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } issue_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/mroe_mem.sv @@
// Element store: one write port and two read ports with registered read data.
// Depends on mroe_pkg for the element width.
`default_nettype none

module mroe_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [mroe_pkg::DATA_W-1:0]   wdata,
  input  wire logic [AW-1:0]                 raddr_a,
  input  wire logic [AW-1:0]                 raddr_b,
  output logic      [mroe_pkg::DATA_W-1:0]   rdata_a,
  output logic      [mroe_pkg::DATA_W-1:0]   rdata_b
);

  logic [mroe_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ rtl/mroe_alu.sv @@
// Column pipeline: multiply, add and clamp one element per issued word, then write back.
// Depends on mroe_pkg; fed by mroe_seq and the read ports of mroe_mem.
`default_nettype none

module mroe_alu #(
  parameter int AW = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire mroe_pkg::issue_t                     iss,
  input  wire logic [AW-1:0]                        iss_addr_a,
  input  wire logic [AW-1:0]                        iss_addr_b,
  input  wire logic signed [mroe_pkg::SCALAR_W-1:0] scalar,
  input  wire logic signed [mroe_pkg::DATA_W-1:0]   value,
  input  wire logic signed [mroe_pkg::DATA_W-1:0]   q_a,
  input  wire logic signed [mroe_pkg::DATA_W-1:0]   q_b,
  input  wire logic                                 sat_clr,
  output logic                                      we,
  output logic [AW-1:0]                             waddr,
  output logic [mroe_pkg::DATA_W-1:0]               wdata,
  output logic                                      busy,
  output logic                                      sat
);

  mroe_pkg::issue_t                       s1_r, s2_r;
  logic [AW-1:0]                          s1_addr_a_r, s1_addr_b_r;
  logic [AW-1:0]                          s2_addr_a_r, s2_addr_b_r;
  logic signed [mroe_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic signed [mroe_pkg::DATA_W-1:0]     qa_r, qb_r, qsel;
  logic                                   s3_valid_r, s3_valid_nxt;
  logic [AW-1:0]                          s3_addr_r;
  logic [mroe_pkg::DATA_W-1:0]            s3_data_r;
  logic                                   sat_r, sat_nxt;
  logic signed [mroe_pkg::SUM_W-1:0]      sum;
  logic                                   ovf;
  logic [mroe_pkg::DATA_W-1:0]            clamped;
  logic                                   s2_arith;
  logic [mroe_pkg::DATA_W-1:0]            s2_data;

  always_comb begin
    qsel     = (s1_r.op == mroe_pkg::OP_ADD) ? q_b : q_a;
    prod_nxt = mroe_pkg::PROD_W'(scalar) * mroe_pkg::PROD_W'(qsel);

    sum = mroe_pkg::SUM_W'(prod_r) +
          ((s2_r.op == mroe_pkg::OP_ADD) ? mroe_pkg::SUM_W'(qa_r) : '0);
    ovf = sum[mroe_pkg::SUM_W-1:mroe_pkg::DATA_W-1] !=
          {(mroe_pkg::SUM_W-mroe_pkg::DATA_W+1){sum[mroe_pkg::SUM_W-1]}};
    if (ovf) begin
      clamped = sum[mroe_pkg::SUM_W-1] ? mroe_pkg::Q_MIN : mroe_pkg::Q_MAX;
    end else begin
      clamped = sum[mroe_pkg::DATA_W-1:0];
    end

    s2_arith = s2_r.valid &&
               (s2_r.op == mroe_pkg::OP_SCALE || s2_r.op == mroe_pkg::OP_ADD);
    case (s2_r.op)
      mroe_pkg::OP_WRITE: s2_data = value;
      mroe_pkg::OP_SWAP:  s2_data = qb_r;
      default:            s2_data = clamped;
    endcase

    s3_valid_nxt = s2_r.valid && (s2_r.op == mroe_pkg::OP_SWAP);
    sat_nxt      = sat_clr ? 1'b0 : (sat_r | (s2_arith && ovf));

    // A swap never issues columns back to back, so its second write never meets a first write.
    if (s3_valid_r) begin
      we    = 1'b1;
      waddr = s3_addr_r;
      wdata = s3_data_r;
    end else begin
      we    = s2_r.valid;
      waddr = s2_addr_a_r;
      wdata = s2_data;
    end

    busy = s1_r.valid | s2_r.valid | s3_valid_r;
    sat  = sat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r       <= '0;
      s2_r       <= '0;
      s3_valid_r <= 1'b0;
      sat_r      <= 1'b0;
    end else begin
      s1_r       <= iss;
      s2_r       <= s1_r;
      s3_valid_r <= s3_valid_nxt;
      sat_r      <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_a_r <= iss_addr_a;
    s1_addr_b_r <= iss_addr_b;
    s2_addr_a_r <= s1_addr_a_r;
    s2_addr_b_r <= s1_addr_b_r;
    prod_r      <= prod_nxt;
    qa_r        <= q_a;
    qb_r        <= q_b;
    s3_addr_r   <= s2_addr_b_r;
    s3_data_r   <= qa_r;
  end

`ifndef NO_ASSERTIONS
  a_no_write_collision: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> !s2_r.valid)
    else $error("swap second write met another write");

  a_s3_from_swap: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> $past(s2_r.valid && s2_r.op == mroe_pkg::OP_SWAP))
    else $error("second write stage loaded without a swap");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    s2_r.valid |-> $past(s1_r.valid))
    else $error("pipeline stage two valid without stage one");
`endif

endmodule

`default_nettype wire

@@ rtl/mroe_seq.sv @@
// Sequencer: size registers, index checks, column walk and result word.
// Depends on mroe_pkg; drives mroe_mem read addresses and the mroe_alu issue port.
`default_nettype none

module mroe_seq #(
  parameter int MAX_ROWS = mroe_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mroe_pkg::MAX_COLS_DEF,
  parameter int AW       = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [mroe_pkg::FUNC_W-1:0]          in_func,
  input  wire logic [mroe_pkg::IDX_W-1:0]           in_row_a,
  input  wire logic [mroe_pkg::IDX_W-1:0]           in_row_b,
  input  wire logic [mroe_pkg::IDX_W-1:0]           in_col,
  input  wire logic signed [mroe_pkg::SCALAR_W-1:0] in_scalar,
  input  wire logic signed [mroe_pkg::DATA_W-1:0]   in_value,
  input  wire logic                                 cfg_we,
  input  wire logic [mroe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mroe_pkg::SIZE_W-1:0]          cfg_data,
  output mroe_pkg::issue_t                          iss,
  output logic [AW-1:0]                             addr_a,
  output logic [AW-1:0]                             addr_b,
  output logic signed [mroe_pkg::SCALAR_W-1:0]      scalar,
  output logic signed [mroe_pkg::DATA_W-1:0]        value,
  output logic                                      sat_clr,
  input  wire logic signed [mroe_pkg::DATA_W-1:0]   q_a,
  input  wire logic                                 alu_busy,
  input  wire logic                                 alu_sat,
  output logic                                      out_valid,
  output logic signed [mroe_pkg::DATA_W-1:0]        out_read_value,
  output logic                                      out_status,
  output logic                                      out_saturated
);

  mroe_pkg::state_t                       state_r, state_nxt;
  logic [mroe_pkg::SIZE_W-1:0]            rows_r, cols_r;
  logic [mroe_pkg::FUNC_W-1:0]            func_r;
  logic [mroe_pkg::IDX_W-1:0]             ra_r, rb_r, col_r;
  logic signed [mroe_pkg::SCALAR_W-1:0]   scalar_r;
  logic signed [mroe_pkg::DATA_W-1:0]     value_r;
  logic [mroe_pkg::CNT_W-1:0]             k_r, k_nxt;
  logic                                   phase_r, phase_nxt;
  logic                                   err_r, err_nxt;
  logic signed [mroe_pkg::DATA_W-1:0]     rd_val_r, rd_val_nxt;
  logic                                   out_valid_r, out_valid_nxt;
  logic signed [mroe_pkg::DATA_W-1:0]     out_read_r, out_read_nxt;
  logic                                   out_status_r, out_status_nxt;
  logic                                   out_sat_r, out_sat_nxt;
  logic [mroe_pkg::CNT_W-1:0]             nr, nc, cidx;
  logic                                   ra_ok, rb_ok, c_ok, accept, row_op;
  mroe_pkg::op_t                          op;

  always_comb begin
    nr = (mroe_pkg::CNT_W'(rows_r) > mroe_pkg::CNT_W'(MAX_ROWS)) ?
         mroe_pkg::CNT_W'(MAX_ROWS) : mroe_pkg::CNT_W'(rows_r);
    nc = (mroe_pkg::CNT_W'(cols_r) > mroe_pkg::CNT_W'(MAX_COLS)) ?
         mroe_pkg::CNT_W'(MAX_COLS) : mroe_pkg::CNT_W'(cols_r);
    ra_ok  = mroe_pkg::CNT_W'(in_row_a) < nr;
    rb_ok  = mroe_pkg::CNT_W'(in_row_b) < nr;
    c_ok   = mroe_pkg::CNT_W'(in_col) < nc;
    accept = start && (state_r == mroe_pkg::ST_IDLE);
    busy   = (state_r != mroe_pkg::ST_IDLE);

    case (in_func)
      mroe_pkg::FUNC_WRITE: err_nxt = !(ra_ok && c_ok);
      mroe_pkg::FUNC_READ:  err_nxt = !(ra_ok && c_ok);
      mroe_pkg::FUNC_SWAP:  err_nxt = !(ra_ok && rb_ok);
      mroe_pkg::FUNC_ADD:   err_nxt = !(ra_ok && rb_ok);
      mroe_pkg::FUNC_SCALE: err_nxt = !ra_ok;
      default:              err_nxt = 1'b0;
    endcase
    row_op = (in_func == mroe_pkg::FUNC_SWAP) || (in_func == mroe_pkg::FUNC_SCALE) ||
             (in_func == mroe_pkg::FUNC_ADD);

    case (func_r)
      mroe_pkg::FUNC_SWAP:  op = mroe_pkg::OP_SWAP;
      mroe_pkg::FUNC_SCALE: op = mroe_pkg::OP_SCALE;
      mroe_pkg::FUNC_ADD:   op = mroe_pkg::OP_ADD;
      default:              op = mroe_pkg::OP_WRITE;
    endcase

    cidx   = (state_r == mroe_pkg::ST_RUN) ? k_r : mroe_pkg::CNT_W'(col_r);
    addr_a = AW'(mroe_pkg::CALC_W'(ra_r) * mroe_pkg::CALC_W'(MAX_COLS) +
                 mroe_pkg::CALC_W'(cidx));
    addr_b = AW'(mroe_pkg::CALC_W'(rb_r) * mroe_pkg::CALC_W'(MAX_COLS) +
                 mroe_pkg::CALC_W'(k_r));
    scalar = scalar_r;
    value  = value_r;

    state_nxt      = state_r;
    iss.valid      = 1'b0;
    iss.op         = op;
    k_nxt          = k_r;
    phase_nxt      = phase_r;
    rd_val_nxt     = rd_val_r;
    sat_clr        = 1'b0;
    out_valid_nxt  = 1'b0;
    out_read_nxt   = out_read_r;
    out_status_nxt = out_status_r;
    out_sat_nxt    = out_sat_r;

    case (state_r)
      mroe_pkg::ST_IDLE: begin
        if (accept) begin
          sat_clr    = 1'b1;
          k_nxt      = '0;
          phase_nxt  = 1'b0;
          rd_val_nxt = '0;
          if (err_nxt) begin
            state_nxt = mroe_pkg::ST_DONE;
          end else if (in_func == mroe_pkg::FUNC_WRITE) begin
            state_nxt = mroe_pkg::ST_WRITE;
          end else if (in_func == mroe_pkg::FUNC_READ) begin
            state_nxt = mroe_pkg::ST_READ;
          end else if (row_op && (nc != '0)) begin
            state_nxt = mroe_pkg::ST_RUN;
          end else begin
            state_nxt = mroe_pkg::ST_DONE;
          end
        end
      end
      mroe_pkg::ST_WRITE: begin
        iss.valid = 1'b1;
        state_nxt = mroe_pkg::ST_DRAIN;
      end
      mroe_pkg::ST_READ: begin
        state_nxt = mroe_pkg::ST_READ_WAIT;
      end
      mroe_pkg::ST_READ_WAIT: begin
        rd_val_nxt = q_a;
        state_nxt  = mroe_pkg::ST_DONE;
      end
      mroe_pkg::ST_RUN: begin
        iss.valid = !((func_r == mroe_pkg::FUNC_SWAP) && phase_r);
        phase_nxt = (func_r == mroe_pkg::FUNC_SWAP) ? !phase_r : 1'b0;
        if (iss.valid) begin
          k_nxt = mroe_pkg::CNT_W'(k_r + 1'b1);
          if (mroe_pkg::CNT_W'(k_r + 1'b1) == nc) begin
            state_nxt = mroe_pkg::ST_DRAIN;
          end
        end
      end
      mroe_pkg::ST_DRAIN: begin
        if (!alu_busy) begin
          state_nxt = mroe_pkg::ST_DONE;
        end
      end
      mroe_pkg::ST_DONE: begin
        out_valid_nxt  = 1'b1;
        out_read_nxt   = rd_val_r;
        out_status_nxt = err_r;
        out_sat_nxt    = alu_sat;
        state_nxt      = mroe_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mroe_pkg::ST_IDLE;
      end
    endcase

    out_valid      = out_valid_r;
    out_read_value = out_read_r;
    out_status     = out_status_r;
    out_saturated  = out_sat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mroe_pkg::ST_IDLE;
      rows_r      <= mroe_pkg::SIZE_RESET;
      cols_r      <= mroe_pkg::SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mroe_pkg::CFG_ROWS: rows_r <= cfg_data;
          mroe_pkg::CFG_COLS: cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_func;
      ra_r     <= in_row_a;
      rb_r     <= in_row_b;
      col_r    <= in_col;
      scalar_r <= in_scalar;
      value_r  <= in_value;
      err_r    <= err_nxt;
    end
    k_r          <= k_nxt;
    phase_r      <= phase_nxt;
    rd_val_r     <= rd_val_nxt;
    out_read_r   <= out_read_nxt;
    out_status_r <= out_status_nxt;
    out_sat_r    <= out_sat_nxt;
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not make the block busy");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == mroe_pkg::ST_IDLE))
    else $error("result word shown while still working");

  a_swap_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (iss.valid && iss.op == mroe_pkg::OP_SWAP) |=> !iss.valid)
    else $error("swap columns issued back to back");

  a_issue_state: assert property (@(posedge clk) disable iff (!rst_n)
    iss.valid |-> (state_r == mroe_pkg::ST_RUN || state_r == mroe_pkg::ST_WRITE))
    else $error("column issued outside a working state");
`endif

endmodule

`default_nettype wire

@@ rtl/matrix_row_operation_engine_core.sv @@
// Top level of the matrix row operation engine: sequencer, column pipeline and element store.
// Depends on mroe_pkg, mroe_seq, mroe_alu and mroe_mem.
`default_nettype none

// The block takes one command word while busy is low and start is high, and returns exactly
// one result word, marked by out_valid for a single cycle; the receiver cannot stall it.
// A swap cannot issue its columns back to back: the element store has one write port, so
// each column of a swap needs two writes, while scale and add stream one column per cycle
// through the multiply and clamp stages. Elements are undefined until written.
module matrix_row_operation_engine_core #(
  parameter int MAX_ROWS = mroe_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mroe_pkg::MAX_COLS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [mroe_pkg::FUNC_W-1:0]          in_func,
  input  wire logic [mroe_pkg::IDX_W-1:0]           in_row_a,
  input  wire logic [mroe_pkg::IDX_W-1:0]           in_row_b,
  input  wire logic [mroe_pkg::IDX_W-1:0]           in_col,
  input  wire logic signed [mroe_pkg::SCALAR_W-1:0] in_scalar,
  input  wire logic signed [mroe_pkg::DATA_W-1:0]   in_value,
  output logic                                      out_valid,
  output logic signed [mroe_pkg::DATA_W-1:0]        out_read_value,
  output logic                                      out_status,
  output logic                                      out_saturated,
  input  wire logic                                 cfg_we,
  input  wire logic [mroe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mroe_pkg::SIZE_W-1:0]          cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  mroe_pkg::issue_t                       iss;
  logic [AW-1:0]                          addr_a, addr_b, waddr;
  logic signed [mroe_pkg::SCALAR_W-1:0]   scalar;
  logic signed [mroe_pkg::DATA_W-1:0]     value;
  logic                                   sat_clr, alu_busy, alu_sat, we;
  logic [mroe_pkg::DATA_W-1:0]            wdata, q_a, q_b;

  mroe_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_row_a       (in_row_a),
    .in_row_b       (in_row_b),
    .in_col         (in_col),
    .in_scalar      (in_scalar),
    .in_value       (in_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .iss            (iss),
    .addr_a         (addr_a),
    .addr_b         (addr_b),
    .scalar         (scalar),
    .value          (value),
    .sat_clr        (sat_clr),
    .q_a            (q_a),
    .alu_busy       (alu_busy),
    .alu_sat        (alu_sat),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_saturated  (out_saturated)
  );

  mroe_alu #(
    .AW (AW)
  ) u_alu (
    .clk        (clk),
    .rst_n      (rst_n),
    .iss        (iss),
    .iss_addr_a (addr_a),
    .iss_addr_b (addr_b),
    .scalar     (scalar),
    .value      (value),
    .q_a        (q_a),
    .q_b        (q_b),
    .sat_clr    (sat_clr),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .busy       (alu_busy),
    .sat        (alu_sat)
  );

  mroe_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (q_a),
    .rdata_b (q_b)
  );

endmodule

`default_nettype wire
